// File: hdl/spq_pkg.sv
// Shared constants, operation codes and controller/datapath interface types.
`default_nettype none

package spq_pkg;

  // Queue geometry
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  // Payload widths
  localparam int HANDLE_W     = 32;
  localparam int PRIO_W       = 32;
  localparam int FUNC_W       = 2;
  localparam int IN_DATA_W    = ((HANDLE_W + PRIO_W + 7) / 8) * 8;
  localparam int OUT_RAW_W    = HANDLE_W + PRIO_W + CNT_W;
  localparam int OUT_DATA_W   = ((OUT_RAW_W + 7) / 8) * 8;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd2;

  // Commands from the controller
  typedef struct packed {
    logic load;   // capture a new request, rewind the walk index
    logic step;   // advance the walk index by one entry
    logic apply;  // commit the update and load the result register
  } ctrl_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic stop;      // walk has reached its position
    logic out_free;  // result register can take a new result this cycle
  } dp_sts_t;

endpackage

`default_nettype wire

// File: hdl/stable_priority_queue.sv
// Top level of the stable priority queue of object handles.
`default_nettype none

// Channel    Dir  tdata (low bit up)                        tuser
// s_axis     in   handle_in[31:0], prio_in[63:32]           func[1:0]
// m_axis     out  handle_out[31:0], prio_out[63:32],        ok
//                 fill[68:64], zero pad to 72
//
// Each request passes through three controller states: accept, a walk in which
// the shared comparators check one entry per step until the stop position, and
// an update that shifts the entry cells and loads the result register.
// Reset empties the queue at once; no clearing pass is needed.
// A result waits in its register while the next request is accepted; a
// stalled result only holds the update step of the following request.

module stable_priority_queue (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire [spq_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,  // handle_in, prio_in
  input  wire [spq_pkg::FUNC_W-1:0]      s_axis_tuser_i,  // func
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  output logic [spq_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,  // handle_out, prio_out, fill
  output logic                           m_axis_tuser_o   // ok
);

  spq_pkg::ctrl_cmd_t cmd;
  spq_pkg::dp_sts_t   sts;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// File: hdl/spq_dp.sv
// Datapath: entry cells, walk index, comparator and result register.
`default_nettype none

module spq_dp (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire spq_pkg::ctrl_cmd_t        cmd_i,
  output spq_pkg::dp_sts_t               sts_o,
  input  wire [spq_pkg::IN_DATA_W-1:0]   s_tdata_i,
  input  wire [spq_pkg::FUNC_W-1:0]      s_tuser_i,
  output logic                           m_tvalid_o,
  input  wire                            m_tready_i,
  output logic [spq_pkg::OUT_DATA_W-1:0] m_tdata_o,
  output logic                           m_tuser_o
);

  localparam int CAP = spq_pkg::CAPACITY;

  // Request registers
  logic [spq_pkg::FUNC_W-1:0]   func_q;
  logic [spq_pkg::HANDLE_W-1:0] handle_q;
  logic [spq_pkg::PRIO_W-1:0]   prio_q;

  // Walk index and fill count
  logic [spq_pkg::CNT_W-1:0] idx_q, idx_d;
  logic [spq_pkg::CNT_W-1:0] count_q, count_d;

  // Entry cells, head at index zero
  logic [spq_pkg::HANDLE_W-1:0] ent_handle_q [CAP];
  logic [spq_pkg::PRIO_W-1:0]   ent_prio_q   [CAP];

  // Result register
  logic                         out_valid_q, out_valid_d;
  logic                         out_ok_q;
  logic [spq_pkg::HANDLE_W-1:0] out_handle_q;
  logic [spq_pkg::PRIO_W-1:0]   out_prio_q;
  logic [spq_pkg::CNT_W-1:0]    out_fill_q;

  logic [spq_pkg::HANDLE_W-1:0] cur_handle;
  logic [spq_pkg::PRIO_W-1:0]   cur_prio;
  logic [spq_pkg::IDX_W-1:0]    pos;
  logic                         at_end, full, null_h;
  logic                         walk_stop;
  logic                         ins_ok, del_ok, pop_ok, shift_l;

  // Look at the entry under the walk index
  assign pos        = idx_q[spq_pkg::IDX_W-1:0];
  assign cur_handle = ent_handle_q[pos];
  assign cur_prio   = ent_prio_q[pos];
  assign at_end     = (idx_q == count_q);
  assign full       = (count_q == spq_pkg::CNT_W'(CAP));
  assign null_h     = (handle_q == '0);

  // Decide where the walk stops
  always_comb begin
    case (func_q)
      spq_pkg::FUNC_INSERT: walk_stop = at_end | null_h | full | (cur_prio < prio_q);
      spq_pkg::FUNC_DELETE: walk_stop = at_end | null_h | (cur_handle == handle_q);
      default:              walk_stop = 1'b1;
    endcase
  end
  assign sts_o = '{stop: walk_stop, out_free: ~out_valid_q | m_tready_i};

  // Outcome of the request at the stop position
  assign ins_ok  = cmd_i.apply & (func_q == spq_pkg::FUNC_INSERT) & ~null_h & ~full;
  assign del_ok  = cmd_i.apply & (func_q == spq_pkg::FUNC_DELETE) & ~null_h & ~at_end;
  assign pop_ok  = cmd_i.apply & (func_q == spq_pkg::FUNC_POP) & (count_q != '0);
  assign shift_l = del_ok | pop_ok;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.step) begin
      idx_d = idx_q + spq_pkg::CNT_W'(1);
    end
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + spq_pkg::CNT_W'(1);
    end else if (shift_l) begin
      count_d = count_q - spq_pkg::CNT_W'(1);
    end
    out_valid_d = out_valid_q;
    if (cmd_i.apply) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request and the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= s_tuser_i;
      handle_q <= s_tdata_i[spq_pkg::HANDLE_W-1:0];
      prio_q   <= s_tdata_i[spq_pkg::HANDLE_W +: spq_pkg::PRIO_W];
    end
    if (cmd_i.apply) begin
      out_ok_q     <= ins_ok | del_ok | pop_ok;
      out_handle_q <= pop_ok ? ent_handle_q[0] : '0;
      out_prio_q   <= pop_ok ? ent_prio_q[0] : '0;
      out_fill_q   <= count_d;
    end
  end

  // Entry cells: open a gap at the stop position or close it
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [spq_pkg::IDX_W-1:0] my_idx;
    assign my_idx = spq_pkg::IDX_W'(i);

    always_ff @(posedge clk_i) begin
      if (ins_ok && my_idx == pos) begin
        ent_handle_q[i] <= handle_q;
        ent_prio_q[i]   <= prio_q;
      end else if (ins_ok && my_idx > pos) begin
        if (i > 0) begin
          ent_handle_q[i] <= ent_handle_q[(i > 0) ? i - 1 : 0];
          ent_prio_q[i]   <= ent_prio_q[(i > 0) ? i - 1 : 0];
        end
      end else if (shift_l && my_idx >= pos) begin
        if (i < CAP - 1) begin
          ent_handle_q[i] <= ent_handle_q[(i < CAP - 1) ? i + 1 : i];
          ent_prio_q[i]   <= ent_prio_q[(i < CAP - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Drive the result channel
  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_ok_q;
  assign m_tdata_o  = spq_pkg::OUT_DATA_W'({out_fill_q, out_prio_q, out_handle_q});

endmodule

`default_nettype wire

// File: hdl/spq_ctrl.sv
// Controller: sequences accept, walk and update for each request.
`default_nettype none

module spq_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_tvalid_i,
  output logic                s_tready_o,
  input  wire spq_pkg::dp_sts_t sts_i,
  output spq_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_APPLY
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_tvalid_i) state_d = ST_WALK;
      ST_WALK:  if (sts_i.stop) state_d = ST_APPLY;
      ST_APPLY: if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Issue commands
  assign s_tready_o = (state_q == ST_IDLE);
  assign cmd_o = '{load:  (state_q == ST_IDLE) & s_tvalid_i,
                   step:  (state_q == ST_WALK) & ~sts_i.stop,
                   apply: (state_q == ST_APPLY) & sts_i.out_free};

endmodule

`default_nettype wire

// File: hdl/spq_checker.sv
// Port-level checks for the stable priority queue, bound to the top level.
`default_nettype none

module spq_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            s_axis_tvalid_i,
  input wire                            s_axis_tready_o,
  input wire                            m_axis_tvalid_o,
  input wire                            m_axis_tready_i,
  input wire [spq_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  input wire                            m_axis_tuser_o
);

  localparam int HW = spq_pkg::HANDLE_W;
  localparam int PW = spq_pkg::PRIO_W;

  // Fill never exceeds the capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o[HW+PW +: spq_pkg::CNT_W] <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
    else $error("fill above capacity");

  // A failed request returns a null handle and zero priority
  a_fail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |->
      (m_axis_tdata_o[HW+PW-1:0] == '0))
    else $error("failed result carries data");

  // Ready drops straight after an accepted request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready right after accept");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

// File: sim/tb_stable_priority_queue.sv
`timescale 1ns / 1ps
// Testbench for the stable priority queue: directed and random requests against a shadow queue.
module tb_stable_priority_queue;

  // Reserved operation code; the block answers it without touching the queue
  localparam logic [spq_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS    = 1850;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int IDLE_LIMIT      = 5000;
  localparam int SETTLE_CYCLES   = spq_pkg::CAPACITY + 8;

  typedef struct packed {
    logic                         ok;
    logic [spq_pkg::HANDLE_W-1:0] handle;
    logic [spq_pkg::PRIO_W-1:0]   prio;
    logic [spq_pkg::CNT_W-1:0]    fill;
  } queue_result_t;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [spq_pkg::IN_DATA_W-1:0]  s_axis_tdata_i  = '0;  // handle_in, prio_in
  logic [spq_pkg::FUNC_W-1:0]     s_axis_tuser_i  = '0;  // func
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [spq_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;        // handle_out, prio_out, fill
  logic                           m_axis_tuser_o;        // ok

  // Shadow copy of the queue contents, head at index 0
  logic [spq_pkg::HANDLE_W-1:0] shadow_handle [spq_pkg::CAPACITY];
  logic [spq_pkg::PRIO_W-1:0]   shadow_prio   [spq_pkg::CAPACITY];
  int                           shadow_count = 0;

  queue_result_t pending_results [$];

  int error_count     = 0;
  int results_checked = 0;
  int requests_sent   = 0;
  int inserts_done    = 0;
  int full_rejects    = 0;
  int deletes_hit     = 0;
  int pops_done       = 0;
  int pops_empty      = 0;
  int peak_fill       = 0;

  bit sender_gaps  = 1'b0;
  int burst_left   = 0;
  bit hold_off_req = 1'b0;

  stable_priority_queue dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one request to the shadow queue and return the result it must produce
  function automatic queue_result_t predict_queue_op(
      input logic [spq_pkg::FUNC_W-1:0]   func,
      input logic [spq_pkg::HANDLE_W-1:0] handle,
      input logic [spq_pkg::PRIO_W-1:0]   prio);
    queue_result_t res;
    int pos;
    int drop_at;
    int idx;
    res = '0;
    drop_at = -1;
    case (func)
      spq_pkg::FUNC_INSERT: begin
        if (handle != '0 && shadow_count < spq_pkg::CAPACITY) begin
          // land behind every entry of greater or equal priority
          pos = shadow_count;
          while (pos > 0 && shadow_prio[pos-1] < prio) pos--;
          for (idx = shadow_count; idx > pos; idx--) begin
            shadow_handle[idx] = shadow_handle[idx-1];
            shadow_prio[idx]   = shadow_prio[idx-1];
          end
          shadow_handle[pos] = handle;
          shadow_prio[pos]   = prio;
          shadow_count++;
          res.ok = 1'b1;
          inserts_done++;
        end else if (handle != '0) begin
          full_rejects++;
        end
      end
      spq_pkg::FUNC_DELETE: begin
        // first match counted from the head
        if (handle != '0) begin
          for (idx = 0; idx < shadow_count && drop_at < 0; idx++) begin
            if (shadow_handle[idx] == handle) drop_at = idx;
          end
        end
        if (drop_at >= 0) begin
          res.ok = 1'b1;
          deletes_hit++;
        end
      end
      spq_pkg::FUNC_POP: begin
        if (shadow_count > 0) begin
          res.ok     = 1'b1;
          res.handle = shadow_handle[0];
          res.prio   = shadow_prio[0];
          drop_at    = 0;
          pops_done++;
        end else begin
          pops_empty++;
        end
      end
      default: ;
    endcase
    // close the gap left by a removed entry
    if (drop_at >= 0) begin
      for (idx = drop_at; idx + 1 < shadow_count; idx++) begin
        shadow_handle[idx] = shadow_handle[idx+1];
        shadow_prio[idx]   = shadow_prio[idx+1];
      end
      shadow_count--;
    end
    res.fill = spq_pkg::CNT_W'(shadow_count);
    if (shadow_count > peak_fill) peak_fill = shadow_count;
    return res;
  endfunction

  // Handles mostly from a small pool so that deletes hit and duplicates occur
  function automatic logic [spq_pkg::HANDLE_W-1:0] pick_handle();
    case ($urandom_range(0, 19))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return $urandom;
      default:    return spq_pkg::HANDLE_W'($urandom_range(1, 24));
    endcase
  endfunction

  // Offer one request, hold it until accepted, then record its expected result
  task automatic send_request(input logic [spq_pkg::FUNC_W-1:0]   func,
                              input logic [spq_pkg::HANDLE_W-1:0] handle,
                              input logic [spq_pkg::PRIO_W-1:0]   prio);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {prio, handle};
    s_axis_tuser_i  <= func;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(predict_queue_op(func, handle, prio));
    requests_sent++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_results_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_and_null();
    sender_gaps = 1'b1;
    send_request(spq_pkg::FUNC_POP, '0, '0);
    send_request(FUNC_UNUSED, '1, '1);
    send_request(spq_pkg::FUNC_INSERT, '0, 32'd5);
    send_request(spq_pkg::FUNC_DELETE, '0, '0);
    send_request(spq_pkg::FUNC_DELETE, 32'h0000_1234, '0);
    wait_results_drained();
  endtask

  task automatic test_order_and_extremes();
    sender_gaps = 1'b1;
    send_request(spq_pkg::FUNC_INSERT, '1, '1);
    send_request(spq_pkg::FUNC_INSERT, 32'd1, '0);
    // equal priorities must come out in arrival order
    send_request(spq_pkg::FUNC_INSERT, 32'd10, 32'd7);
    send_request(spq_pkg::FUNC_INSERT, 32'd11, 32'd7);
    send_request(spq_pkg::FUNC_INSERT, 32'd12, 32'd7);
    send_request(spq_pkg::FUNC_INSERT, 32'd10, 32'd9);
    send_request(spq_pkg::FUNC_INSERT, 32'd20, 32'h8000_0000);
    // duplicate handle: the copy nearer the head goes
    send_request(spq_pkg::FUNC_DELETE, 32'd10, '0);
    send_request(spq_pkg::FUNC_DELETE, 32'd12, '0);
    send_request(spq_pkg::FUNC_DELETE, 32'h77, '0);
    send_request(FUNC_UNUSED, '0, '0);
    repeat (6) send_request(spq_pkg::FUNC_POP, '0, '0);
    wait_results_drained();
  endtask

  // Stall the result side while inserts keep coming, overfilling the queue
  task automatic test_full_under_backpressure();
    int k;
    sender_gaps = 1'b0;
    while (shadow_count > 0) send_request(spq_pkg::FUNC_POP, '0, '0);
    hold_off_req = 1'b1;
    for (k = 0; k < spq_pkg::CAPACITY + 6; k++) begin
      send_request(spq_pkg::FUNC_INSERT, pick_handle() | spq_pkg::HANDLE_W'(1), $urandom);
    end
    send_request(spq_pkg::FUNC_DELETE, 32'h2, '0);
    send_request(spq_pkg::FUNC_INSERT, '0, '1);
    send_request(spq_pkg::FUNC_POP, '0, '0);
    wait_results_drained();
  endtask

  // Phases that push the queue toward full or empty, with random content
  task automatic test_random_traffic();
    int n;
    int phase_left;
    int ins_w;
    int del_w;
    int roll;
    logic [spq_pkg::FUNC_W-1:0]   func;
    logic [spq_pkg::HANDLE_W-1:0] handle;
    logic [spq_pkg::PRIO_W-1:0]   prio;
    phase_left = 0;
    ins_w = 40;
    del_w = 20;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left  = $urandom_range(30, 150);
        sender_gaps = ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 2))
          0:       begin ins_w = 70; del_w = 10; end
          1:       begin ins_w = 25; del_w = 20; end
          default: begin ins_w = 40; del_w = 25; end
        endcase
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) func = FUNC_UNUSED;
      else if (roll < 3 + ins_w) func = spq_pkg::FUNC_INSERT;
      else if (roll < 3 + ins_w + del_w) func = spq_pkg::FUNC_DELETE;
      else func = spq_pkg::FUNC_POP;
      handle = pick_handle();
      if (func == spq_pkg::FUNC_DELETE && shadow_count > 0 && $urandom_range(0, 9) < 6) begin
        handle = shadow_handle[$urandom_range(0, shadow_count - 1)];
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: prio = spq_pkg::PRIO_W'($urandom_range(0, 7));
        4:          prio = '1;
        5:          prio = ~spq_pkg::PRIO_W'($urandom_range(0, 7));
        default:    prio = $urandom;
      endcase
      send_request(func, handle, prio);
    end
    wait_results_drained();
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    queue_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: tdata %h ok %b", m_axis_tdata_o, m_axis_tuser_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (m_axis_tuser_o !== want.ok) begin
          $error("ok mismatch: expected %b, got %b", want.ok, m_axis_tuser_o);
          error_count++;
        end
        if (m_axis_tdata_o[spq_pkg::HANDLE_W-1:0] !== want.handle) begin
          $error("handle_out mismatch: expected %h, got %h", want.handle,
                 m_axis_tdata_o[spq_pkg::HANDLE_W-1:0]);
          error_count++;
        end
        if (m_axis_tdata_o[spq_pkg::HANDLE_W +: spq_pkg::PRIO_W] !== want.prio) begin
          $error("prio_out mismatch: expected %h, got %h", want.prio,
                 m_axis_tdata_o[spq_pkg::HANDLE_W +: spq_pkg::PRIO_W]);
          error_count++;
        end
        if (m_axis_tdata_o[spq_pkg::HANDLE_W + spq_pkg::PRIO_W +: spq_pkg::CNT_W]
            !== want.fill) begin
          $error("fill mismatch: expected %0d, got %0d", want.fill,
                 m_axis_tdata_o[spq_pkg::HANDLE_W + spq_pkg::PRIO_W +: spq_pkg::CNT_W]);
          error_count++;
        end
      end
    end
  end

  // Result-side stall pattern, with a long hold-off on request
  initial begin : receiver
    rx_mode_e mode;
    int span;
    mode = RX_FREE;
    span = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk_i);
      end else begin
        if (span == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          span = $urandom_range(10, 200);
        end
        span--;
        case (mode)
          RX_FREE:   m_axis_tready_i <= 1'b1;
          RX_COIN:   m_axis_tready_i <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: m_axis_tready_i <= ($urandom_range(0, 5) == 0);
          default:   m_axis_tready_i <= (span % 3 == 0);
        endcase
      end
    end
  end

  // End the run when nothing moves on either side for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $error("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : run_tests
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_null();
    test_order_and_extremes();
    test_full_under_backpressure();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end
    $display("Sent %0d requests: %0d inserts, %0d full rejects, %0d delete hits,",
             requests_sent, inserts_done, full_rejects, deletes_hit);
    $display("%0d pops, %0d empty pops; checked %0d results, peak fill %0d of %0d, %0d errors",
             pops_done, pops_empty, results_checked, peak_fill, spq_pkg::CAPACITY,
             error_count);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
